>>> rtl/blb_pkg.sv
// Shared constants, types and state codes for the backend load balancer.
package blb_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int DIV_W     = 64;
    localparam int DIV_CW    = $clog2(DIV_W);
    // divisor holds the eligible count
    localparam int DIV_DW    = CNT_W;
    localparam int SUM_W     = 36;
    // divide-by-ten steps for the latency average
    localparam int D10_STEPS = 7;
    localparam int D10_SW    = 3;

    localparam logic [2:0] CMD_SELECT = 3'd0;
    localparam logic [2:0] CMD_REPORT = 3'd1;
    localparam logic [2:0] CMD_HEALTH = 3'd2;
    localparam logic [2:0] CMD_ADD    = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    localparam logic [1:0] STRAT_RR   = 2'd0;
    localparam logic [1:0] STRAT_LC   = 2'd1;
    localparam logic [1:0] STRAT_WL   = 2'd2;
    localparam logic [1:0] STRAT_HASH = 2'd3;

    localparam logic [1:0] STRAT_RESET = STRAT_LC;

    typedef struct packed {
        logic [15:0] weight;
        logic [31:0] conns;
        logic [31:0] avg;
        logic [31:0] total;
        logic [31:0] good;
    } t_rec;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PICK,
        ST_INC_RD,
        ST_INC_WR,
        ST_REP_RD,
        ST_REP_MUL,
        ST_REP_SUM,
        ST_REP_DIV,
        ST_REP_WR,
        ST_FIN
    } t_state;

endpackage

>>> rtl/backend_load_balancer.sv
// Backend load balancer top level: command sequencer over the slot record store.
//
//  channel   ports                                       handshake
//  --------  ------------------------------------------  -------------------------------
//  command   i_cmd, i_backend_slot, i_backend_weight,     taken when i_start & !o_busy
//            i_healthy_flag, i_success_flag,
//            i_latency_ms, i_key_hash
//  result    o_chosen_slot, o_found                      valid for one cycle on o_done
//  config    i_cfg_wdata (strategy)                      written when i_cfg_we
//
// One request at a time; o_busy drops as o_done rises, so requests can follow back to back.
// Add, remove, set health, unknown commands and a report on an empty slot go straight to
// the finish state.
// Report: read, two add steps, seven shift-add steps dividing by ten, write.
// Select scans each slot in turn (read, registered cross products, compare). Round robin
// and hash then run the divider for the modulo and walk to the n-th eligible slot; when
// nothing is eligible, select finishes with no slot found.
// Reset (synchronous, active low) clears valid/healthy bits, round robin count and
// strategy (least connections); the record store needs no clearing since add writes
// every field. Results cannot be held off by the receiver.
module backend_load_balancer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_backend_slot,
    input  logic [15:0] i_backend_weight,
    input  logic        i_healthy_flag,
    input  logic        i_success_flag,
    input  logic [31:0] i_latency_ms,
    input  logic [63:0] i_key_hash,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [3:0]  o_chosen_slot,
    output logic        o_found
);

    localparam int SW = blb_pkg::SLOT_W;
    localparam int CW = blb_pkg::CNT_W;

    blb_pkg::t_state r_state, n_state;

    // validity and health live in flops so reset clears them at once
    logic [blb_pkg::NUM_SLOTS-1:0] r_valid;
    logic [blb_pkg::NUM_SLOTS-1:0] r_healthy;
    logic [blb_pkg::NUM_SLOTS-1:0] elig;

    logic [1:0]  r_strategy;
    logic [31:0] r_rr;

    // latched request
    logic [3:0]  r_slot;
    logic        r_sflag;
    logic [31:0] r_lat;
    logic [63:0] r_key;

    // scan state
    logic [SW-1:0] r_scan;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] cnt_next;
    logic          r_have;
    logic [SW-1:0] r_best;
    logic [31:0]   r_best_avg;
    logic [15:0]   r_best_w;
    logic [31:0]   r_best_conns;
    logic [31:0]   r_cur_avg;
    logic [15:0]   r_cur_w;
    logic [31:0]   r_cur_conns;
    logic [47:0]   r_p_new;
    logic [47:0]   r_p_best;
    logic [SW-1:0] r_n;
    logic          scan_last;
    logic          take;
    logic          cur_elig;

    // report datapath
    blb_pkg::t_rec   r_rec;
    logic [blb_pkg::SUM_W-1:0]  r_sum;
    logic [blb_pkg::SUM_W-1:0]  r_q;       // quotient estimate, sum / 10
    logic [blb_pkg::SUM_W-1:0]  r_r10;     // sum - 10 * estimate, below twenty
    logic [blb_pkg::D10_SW-1:0] r_dstep;

    logic        r_done;
    logic [3:0]  r_chosen;
    logic        r_found;

    logic        accept;
    logic        in_range;
    logic [SW-1:0] in_idx;
    logic [SW-1:0] slot_idx;

    // memory and divider hookup
    logic                       ram_we;
    logic [SW-1:0]              ram_waddr;
    blb_pkg::t_rec              ram_wdata;
    logic [SW-1:0]              ram_raddr;
    blb_pkg::t_rec              ram_rdata;
    logic                       div_start;
    logic [blb_pkg::DIV_W-1:0]  div_dividend;
    logic [blb_pkg::DIV_DW-1:0] div_divisor;
    logic                       div_done;
    logic [blb_pkg::DIV_DW-1:0] div_rem;

    blb_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    blb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign accept   = i_start && (r_state == blb_pkg::ST_IDLE);
    assign in_range = (32'(i_backend_slot) < blb_pkg::NUM_SLOTS);
    assign in_idx   = SW'(i_backend_slot);
    assign slot_idx = SW'(r_slot);
    assign elig     = r_valid & r_healthy;
    assign cur_elig = elig[r_scan];
    assign scan_last = (r_scan == SW'(blb_pkg::NUM_SLOTS - 1));
    assign cnt_next = r_cnt + CW'(cur_elig);

    // candidate test for the compare step
    always_comb begin
        take = 1'b0;
        if (r_strategy == blb_pkg::STRAT_LC) begin
            take = cur_elig && (!r_have || (r_cur_conns < r_best_conns));
        end else if (r_strategy == blb_pkg::STRAT_WL) begin
            take = cur_elig && (r_cur_w != 16'd0) && (!r_have || (r_p_new < r_p_best));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            blb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == blb_pkg::CMD_SELECT) begin
                        n_state = blb_pkg::ST_SCAN_RD;
                    end else if (i_cmd == blb_pkg::CMD_REPORT && in_range
                                 && r_valid[in_idx]) begin
                        n_state = blb_pkg::ST_REP_RD;
                    end else begin
                        n_state = blb_pkg::ST_FIN;
                    end
                end
            end
            blb_pkg::ST_SCAN_RD:  n_state = blb_pkg::ST_SCAN_MUL;
            blb_pkg::ST_SCAN_MUL: n_state = blb_pkg::ST_SCAN_CMP;
            blb_pkg::ST_SCAN_CMP: begin
                if (!scan_last) begin
                    n_state = blb_pkg::ST_SCAN_RD;
                end else if (r_strategy == blb_pkg::STRAT_RR
                             || r_strategy == blb_pkg::STRAT_HASH) begin
                    n_state = (cnt_next == '0) ? blb_pkg::ST_FIN : blb_pkg::ST_DIV_GO;
                end else begin
                    n_state = (r_have || take) ? blb_pkg::ST_INC_RD : blb_pkg::ST_FIN;
                end
            end
            blb_pkg::ST_DIV_GO:   n_state = blb_pkg::ST_DIV_WAIT;
            blb_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = blb_pkg::ST_PICK;
                end
            end
            blb_pkg::ST_PICK: begin
                if (cur_elig && r_n == '0) begin
                    n_state = blb_pkg::ST_INC_RD;
                end
            end
            blb_pkg::ST_INC_RD:  n_state = blb_pkg::ST_INC_WR;
            blb_pkg::ST_INC_WR:  n_state = blb_pkg::ST_FIN;
            blb_pkg::ST_REP_RD:  n_state = blb_pkg::ST_REP_MUL;
            blb_pkg::ST_REP_MUL: n_state = blb_pkg::ST_REP_SUM;
            blb_pkg::ST_REP_SUM: n_state = blb_pkg::ST_REP_DIV;
            blb_pkg::ST_REP_DIV: begin
                if (r_dstep == blb_pkg::D10_SW'(blb_pkg::D10_STEPS - 1)) begin
                    n_state = blb_pkg::ST_REP_WR;
                end
            end
            blb_pkg::ST_REP_WR:  n_state = blb_pkg::ST_FIN;
            blb_pkg::ST_FIN:     n_state = blb_pkg::ST_IDLE;
            default:             n_state = blb_pkg::ST_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = r_best;
        ram_wdata    = r_rec;
        ram_raddr    = r_scan;
        div_start    = 1'b0;
        div_dividend = (r_strategy == blb_pkg::STRAT_RR) ? {32'd0, r_rr} : r_key;
        div_divisor  = blb_pkg::DIV_DW'(r_cnt);
        case (r_state)
            blb_pkg::ST_IDLE: begin
                if (accept && i_cmd == blb_pkg::CMD_ADD && in_range) begin
                    ram_we           = 1'b1;
                    ram_waddr        = in_idx;
                    ram_wdata        = '0;
                    ram_wdata.weight = i_backend_weight;
                end
            end
            blb_pkg::ST_INC_RD: ram_raddr = r_best;
            blb_pkg::ST_INC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_best;
                ram_wdata = ram_rdata;
                if (ram_rdata.conns != 32'hFFFF_FFFF) begin
                    ram_wdata.conns = ram_rdata.conns + 32'd1;
                end
            end
            blb_pkg::ST_REP_RD: ram_raddr = slot_idx;
            blb_pkg::ST_DIV_GO: div_start = 1'b1;
            blb_pkg::ST_REP_WR: begin
                ram_we          = 1'b1;
                ram_waddr       = slot_idx;
                ram_wdata       = r_rec;
                ram_wdata.total = r_rec.total + 32'd1;
                ram_wdata.good  = r_rec.good + 32'(r_sflag);
                // estimate is at most one low; the remainder tells
                ram_wdata.avg   = (r_rec.avg == 32'd0) ? r_lat
                                : r_q[31:0] + 32'(r_r10 > blb_pkg::SUM_W'(9));
                if (r_rec.conns != 32'd0) begin
                    ram_wdata.conns = r_rec.conns - 32'd1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= blb_pkg::ST_IDLE;
            r_valid    <= '0;
            r_healthy  <= '0;
            r_strategy <= blb_pkg::STRAT_RESET;
            r_rr       <= '0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_chosen   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == blb_pkg::ST_FIN);
            if (i_cfg_we) begin
                r_strategy <= i_cfg_wdata;
            end
            if (accept) begin
                r_found  <= 1'b0;
                r_chosen <= '0;
                if (in_range) begin
                    case (i_cmd)
                        blb_pkg::CMD_ADD: begin
                            r_valid[in_idx]   <= 1'b1;
                            r_healthy[in_idx] <= 1'b1;
                        end
                        blb_pkg::CMD_REMOVE: begin
                            r_valid[in_idx]   <= 1'b0;
                            r_healthy[in_idx] <= 1'b0;
                        end
                        blb_pkg::CMD_HEALTH: begin
                            if (r_valid[in_idx]) begin
                                r_healthy[in_idx] <= i_healthy_flag;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (r_state == blb_pkg::ST_INC_WR) begin
                r_found  <= 1'b1;
                r_chosen <= 4'(r_best);
                if (r_strategy == blb_pkg::STRAT_RR) begin
                    r_rr <= r_rr + 32'd1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot     <= i_backend_slot;
            r_sflag    <= i_success_flag;
            r_lat      <= i_latency_ms;
            r_key      <= i_key_hash;
            r_scan     <= '0;
            r_cnt      <= '0;
            r_have     <= 1'b0;
            r_best     <= '0;
            r_best_w   <= '0;
        end
        case (r_state)
            blb_pkg::ST_SCAN_MUL: begin
                r_cur_avg   <= ram_rdata.avg;
                r_cur_w     <= ram_rdata.weight;
                r_cur_conns <= ram_rdata.conns;
                r_p_new     <= 48'(ram_rdata.avg) * 48'(r_best_w);
                r_p_best    <= 48'(r_best_avg) * 48'(ram_rdata.weight);
            end
            blb_pkg::ST_SCAN_CMP: begin
                r_cnt <= cnt_next;
                if (take) begin
                    r_have       <= 1'b1;
                    r_best       <= r_scan;
                    r_best_avg   <= r_cur_avg;
                    r_best_w     <= r_cur_w;
                    r_best_conns <= r_cur_conns;
                end
                r_scan <= r_scan + 1'b1;
            end
            blb_pkg::ST_DIV_WAIT: begin
                r_n    <= SW'(div_rem);
                r_scan <= '0;
            end
            blb_pkg::ST_PICK: begin
                if (cur_elig) begin
                    if (r_n == '0) begin
                        r_best <= r_scan;
                    end else begin
                        r_n <= r_n - 1'b1;
                    end
                end
                r_scan <= r_scan + 1'b1;
            end
            blb_pkg::ST_REP_MUL: begin
                r_rec <= ram_rdata;
                r_sum <= {1'b0, ram_rdata.avg, 3'd0} - blb_pkg::SUM_W'(ram_rdata.avg);
            end
            blb_pkg::ST_REP_SUM: begin
                r_sum   <= r_sum + {3'd0, r_lat, 1'b0} + blb_pkg::SUM_W'(r_lat)
                           + blb_pkg::SUM_W'(5);
                r_dstep <= '0;
            end
            // sum / 10 by shift-add: q ~ 0.8 * sum, then / 8, then remainder
            blb_pkg::ST_REP_DIV: begin
                r_dstep <= r_dstep + 1'b1;
                case (r_dstep)
                    3'd0:    r_q <= (r_sum >> 1) + (r_sum >> 2);
                    3'd1:    r_q <= r_q + (r_q >> 4);
                    3'd2:    r_q <= r_q + (r_q >> 8);
                    3'd3:    r_q <= r_q + (r_q >> 16);
                    3'd4:    r_q <= r_q + (r_q >> 32);
                    3'd5:    r_q <= r_q >> 3;
                    default: r_r10 <= r_sum - ({r_q[blb_pkg::SUM_W-4:0], 3'd0}
                                               + {r_q[blb_pkg::SUM_W-2:0], 1'b0});
                endcase
            end
            default: ;
        endcase
    end

    assign o_busy        = (r_state != blb_pkg::ST_IDLE);
    assign o_done        = r_done;
    assign o_chosen_slot = r_chosen;
    assign o_found       = r_found;

endmodule

>>> rtl/blb_slot_ram.sv
// Per-slot record store: one write port, one registered read port.
module blb_slot_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [blb_pkg::SLOT_W-1:0]  i_waddr,
    input  blb_pkg::t_rec               i_wdata,
    input  logic [blb_pkg::SLOT_W-1:0]  i_raddr,
    output blb_pkg::t_rec               o_rdata
);

    blb_pkg::t_rec mem [blb_pkg::NUM_SLOTS];
    blb_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/blb_divider.sv
// Restoring divider, one quotient bit per cycle, narrow divisor; remainder only.
module blb_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [blb_pkg::DIV_W-1:0]   i_dividend,
    input  logic [blb_pkg::DIV_DW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [blb_pkg::DIV_DW-1:0]  o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [blb_pkg::DIV_CW-1:0]  r_cnt;
    logic [blb_pkg::DIV_W-1:0]   r_quot;
    logic [blb_pkg::DIV_DW-1:0]  r_rem;
    logic [blb_pkg::DIV_DW-1:0]  r_div;
    logic [blb_pkg::DIV_DW:0]    trial;
    logic                        qbit;
    logic [blb_pkg::DIV_DW:0]    diff;

    always_comb begin
        trial = {r_rem, r_quot[blb_pkg::DIV_W-1]};
        qbit  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == blb_pkg::DIV_CW'(blb_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[blb_pkg::DIV_W-2:0], qbit};
            r_rem  <= qbit ? diff[blb_pkg::DIV_DW-1:0] : trial[blb_pkg::DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
